/* hw/rtl/erf_pkg.sv */
// shared constants for the escaped radio frame receive filter
package erf_pkg;

    localparam int FRAME_MAX = 64;
    localparam int ADDR_W    = $clog2(FRAME_MAX);
    localparam int CNT_W     = $clog2(FRAME_MAX + 1);
    localparam int LEN_W     = 17;
    localparam int IDX_W     = 6;

    localparam logic [7:0] START_MARK = 8'h7E;
    localparam logic [7:0] ESC_MARK   = 8'h7D;
    localparam logic [7:0] ESC_XOR    = 8'h20;
    localparam logic [7:0] API_LONG   = 8'h80;
    localparam logic [7:0] API_SHORT  = 8'h81;
    localparam logic [7:0] BROADCAST  = 8'hFF;
    localparam logic [7:0] SUM_GOOD   = 8'hFF;
    localparam logic [7:0] NODE_RESET = 8'd3;

    localparam logic [CNT_W-1:0] OFFSET_LONG  = CNT_W'(14);
    localparam logic [CNT_W-1:0] OFFSET_SHORT = CNT_W'(8);
    localparam logic [CNT_W-1:0] MIN_PAYLOAD  = CNT_W'(6);
    localparam logic [CNT_W-1:0] API_POS      = CNT_W'(3);
    localparam logic [CNT_W-1:0] LEN_HI_POS   = CNT_W'(1);
    localparam logic [CNT_W-1:0] LEN_LO_POS   = CNT_W'(2);

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(255);
    localparam logic [LEN_W-1:0] LEN_EXTRA = LEN_W'(4);

    localparam logic [2:0] ADDR_NODE = 3'd0;

    typedef logic [7:0] byte_t;

endpackage

/* hw/rtl/escaped_radio_frame_receive_filter_core.sv */
// top level of the escaped radio frame receive filter
//
// s_ channel: raw received serial bytes, still escaped, one per transaction.
// 0x7E opens a frame, 0x7D escapes the next byte. Bytes of a frame go into
// an internal frame buffer; length, api id, destination and checksum are
// tracked as the bytes arrive.
// When the last byte of a frame is accepted and the frame passes all checks,
// the payload (from offset 8 or 14 up to and including the checksum byte)
// is replayed from the buffer on the m_ channel, one transaction per cycle
// while m_ready is high, the first one the cycle after the closing byte.
// m_last_byte marks the end. While a payload is being replayed s_ready is
// low, also while m_ready holds the output off. A stall simply holds the
// current output byte, nothing is lost.
// node_address sits at APB address 0 and resets to 3; write it only while
// the block is idle. Reset clears the frame state and drops any open frame;
// no buffer clearing pass is needed.
module escaped_radio_frame_receive_filter_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_payload_byte,
    output logic [5:0]  m_payload_index,
    output logic        m_last_byte,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import erf_pkg::*;

    localparam logic ST_RECV = 1'b0;
    localparam logic ST_OUT  = 1'b1;

    logic              state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              in_frame_reg, in_frame_next;
    logic              esc_reg, esc_next;
    logic [LEN_W-1:0]  exp_len_reg, exp_len_next;
    byte_t             sum_reg, sum_next;
    byte_t             node_reg;
    byte_t             len_hi_reg, len_hi_next;
    byte_t             api_reg, api_next;
    byte_t             dest_s_reg, dest_s_next;
    byte_t             dest_l_reg, dest_l_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ADDR_W-1:0] last_reg, last_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    byte_t             unesc;
    byte_t             sum_new;
    byte_t             api_cur;
    byte_t             dest;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  offset;
    logic              api_ok;
    logic              good;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    byte_t             rd_data;
    logic              cfg_wr;

    erf_frame_ram #(
        .DEPTH (FRAME_MAX),
        .WIDTH (8)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (unesc),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign unesc   = esc_reg ? (s_rx_byte ^ ESC_XOR) : s_rx_byte;
    assign cnt_inc = count_reg + CNT_W'(1);
    assign sum_new = (count_reg >= API_POS) ? (sum_reg + unesc) : sum_reg;
    assign api_cur = (count_reg == API_POS) ? unesc : api_reg;
    assign api_ok  = (api_cur == API_LONG) || (api_cur == API_SHORT);
    assign offset  = (api_cur == API_LONG) ? OFFSET_LONG : OFFSET_SHORT;
    assign dest    = (api_cur == API_LONG) ? dest_l_reg : dest_s_reg;
    assign good    = (sum_new == SUM_GOOD) && api_ok && (cnt_inc >= offset + MIN_PAYLOAD)
                     && ((dest == node_reg) || (dest == BROADCAST));

    assign s_ready         = (state_reg == ST_RECV);
    assign m_valid         = (state_reg == ST_OUT);
    assign m_payload_byte  = rd_data;
    assign m_payload_index = idx_reg;
    assign m_last_byte     = (rd_ptr_reg == last_reg);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        in_frame_next = in_frame_reg;
        esc_next      = esc_reg;
        exp_len_next  = exp_len_reg;
        sum_next      = sum_reg;
        len_hi_next   = len_hi_reg;
        api_next      = api_reg;
        dest_s_next   = dest_s_reg;
        dest_l_next   = dest_l_reg;
        rd_ptr_next   = rd_ptr_reg;
        last_next     = last_reg;
        idx_next      = idx_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = rd_ptr_reg + ADDR_W'(1);
        unique case (state_reg)
            ST_RECV: begin
                if (s_valid) begin
                    if (s_rx_byte == START_MARK) begin
                        count_next    = CNT_W'(1);
                        esc_next      = 1'b0;
                        in_frame_next = 1'b1;
                        sum_next      = '0;
                    end else if (s_rx_byte == ESC_MARK) begin
                        esc_next = 1'b1;
                    end else if (in_frame_reg) begin
                        esc_next = 1'b0;
                        if (count_reg >= CNT_W'(FRAME_MAX)) begin
                            count_next    = '0;
                            in_frame_next = 1'b0;
                            sum_next      = '0;
                        end else begin
                            wr_en      = 1'b1;
                            count_next = cnt_inc;
                            sum_next   = sum_new;
                            if (count_reg == LEN_HI_POS) begin
                                len_hi_next = unesc;
                            end
                            if (count_reg == LEN_LO_POS) begin
                                exp_len_next = {1'b0, len_hi_reg, unesc} + LEN_EXTRA;
                            end
                            if (count_reg == API_POS) begin
                                api_next = unesc;
                            end
                            if (count_reg == OFFSET_SHORT) begin
                                dest_s_next = unesc;
                            end
                            if (count_reg == OFFSET_LONG) begin
                                dest_l_next = unesc;
                            end
                            if (LEN_W'(cnt_inc) == exp_len_reg) begin
                                count_next    = '0;
                                in_frame_next = 1'b0;
                                sum_next      = '0;
                                if (good) begin
                                    rd_en       = 1'b1;
                                    rd_addr     = offset[ADDR_W-1:0];
                                    rd_ptr_next = offset[ADDR_W-1:0];
                                    last_next   = count_reg[ADDR_W-1:0];
                                    idx_next    = '0;
                                    state_next  = ST_OUT;
                                end
                            end
                        end
                    end
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (rd_ptr_reg == last_reg) begin
                        state_next = ST_RECV;
                    end else begin
                        rd_en       = 1'b1;
                        rd_ptr_next = rd_ptr_reg + ADDR_W'(1);
                        idx_next    = idx_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_RECV;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_RECV;
            count_reg    <= '0;
            in_frame_reg <= 1'b0;
            esc_reg      <= 1'b0;
            exp_len_reg  <= LEN_RESET;
            sum_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            in_frame_reg <= in_frame_next;
            esc_reg      <= esc_next;
            exp_len_reg  <= exp_len_next;
            sum_reg      <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_hi_reg <= len_hi_next;
        api_reg    <= api_next;
        dest_s_reg <= dest_s_next;
        dest_l_reg <= dest_l_next;
        rd_ptr_reg <= rd_ptr_next;
        last_reg   <= last_next;
        idx_reg    <= idx_next;
    end

    // apb register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_NODE);
    assign prdata = (paddr == ADDR_NODE) ? {24'd0, node_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_reg <= NODE_RESET;
        end else if (cfg_wr) begin
            node_reg <= pwdata[7:0];
        end
    end

endmodule

/* hw/rtl/erf_frame_ram.sv */
// frame buffer: one write port, one registered read port
module erf_frame_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* bench/tb_escaped_radio_frame_receive_filter_core.sv */
// testbench for the escaped radio frame receive filter core
module tb_escaped_radio_frame_receive_filter_core;
    timeunit 1ns;
    timeprecision 1ps;

    import erf_pkg::*;

    localparam logic [2:0] ADDR_UNUSED = 3'd4;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        byte_t      data;
        logic [5:0] idx;
        logic       last;
    } payload_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_payload_byte;
    logic [5:0]  m_payload_index;
    logic        m_last_byte;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    escaped_radio_frame_receive_filter_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload_byte  (m_payload_byte),
        .m_payload_index (m_payload_index),
        .m_last_byte     (m_last_byte),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // frame tracking state mirrored from the block
    byte_t            fr_buf [FRAME_MAX];
    int               fr_cnt = 0;
    bit               fr_open = 1'b0;
    bit               esc_armed = 1'b0;
    logic [LEN_W-1:0] fr_len = LEN_RESET;
    byte_t            fr_sum = 8'h00;
    byte_t            node_addr = NODE_RESET;

    byte_t         rx_pending [$];
    payload_beat_t payload_due [$];
    payload_beat_t due_beat;
    bit            rx_taken = 1'b0;
    int            rx_items = 0;
    int            fail_count = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    bit            hold_req = 1'b0;
    int            hold_left = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void track_rx(input byte_t raw);
        byte_t b;
        int    off;
        byte_t dest;
        b = raw;
        if (b == START_MARK) begin
            fr_buf[0] = START_MARK;
            fr_cnt = 1;
            esc_armed = 1'b0;
            fr_open = 1'b1;
            fr_sum = 8'h00;
        end else if (b == ESC_MARK) begin
            esc_armed = 1'b1;
        end else if (fr_open) begin
            if (esc_armed) begin
                b = b ^ ESC_XOR;
                esc_armed = 1'b0;
            end
            if (fr_cnt >= FRAME_MAX) begin
                fr_cnt = 0;
                fr_open = 1'b0;
                fr_sum = 8'h00;
            end else begin
                fr_buf[fr_cnt] = b;
                if (fr_cnt >= int'(API_POS))
                    fr_sum = fr_sum + b;
                fr_cnt++;
                if (fr_cnt == 3)
                    fr_len = {fr_buf[LEN_HI_POS], 8'h00} + fr_buf[LEN_LO_POS] + LEN_EXTRA;
                if (fr_cnt == fr_len) begin
                    if (fr_sum == SUM_GOOD &&
                        (fr_buf[API_POS] == API_LONG || fr_buf[API_POS] == API_SHORT)) begin
                        off = (fr_buf[API_POS] == API_LONG) ? int'(OFFSET_LONG)
                                                             : int'(OFFSET_SHORT);
                        if (fr_cnt >= off + int'(MIN_PAYLOAD)) begin
                            dest = fr_buf[off];
                            if (dest == node_addr || dest == BROADCAST) begin
                                for (int k = off; k < fr_cnt; k++)
                                    payload_due.push_back('{data: fr_buf[k],
                                                            idx: 6'(k - off),
                                                            last: (k == fr_cnt - 1)});
                            end
                        end
                    end
                    fr_cnt = 0;
                    fr_open = 1'b0;
                    esc_armed = 1'b0;
                    fr_sum = 8'h00;
                end
            end
        end
    endfunction

    // input side: acceptance and prediction
    always @(posedge aclk) begin
        rx_taken = aresetn && s_valid && s_ready;
        if (rx_taken)
            track_rx(s_rx_byte);
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || rx_taken) begin
            if (rx_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_rx_byte <= rx_pending.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // output side: backpressure and checking
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (payload_due.size() == 0) begin
                $error("unexpected transaction: payload_byte %0h payload_index %0d",
                       m_payload_byte, m_payload_index);
                fail_count++;
            end else begin
                due_beat = payload_due.pop_front();
                if (m_payload_byte !== due_beat.data) begin
                    $error("payload_byte: expected %0h, got %0h", due_beat.data, m_payload_byte);
                    fail_count++;
                end
                if (m_payload_index !== due_beat.idx) begin
                    $error("payload_index: expected %0d, got %0d", due_beat.idx,
                           m_payload_index);
                    fail_count++;
                end
                if (m_last_byte !== due_beat.last) begin
                    $error("last_byte: expected %0b, got %0b", due_beat.last, m_last_byte);
                    fail_count++;
                end
            end
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_NODE)
            node_addr = data[7:0];
    endtask

    // escape markers always, other bytes now and then
    task automatic push_coded(input byte_t b);
        if (b == START_MARK || b == ESC_MARK ||
            (b != (START_MARK ^ ESC_XOR) && b != (ESC_MARK ^ ESC_XOR) &&
             $urandom_range(7) == 0)) begin
            rx_pending.push_back(ESC_MARK);
            rx_pending.push_back(b ^ ESC_XOR);
            rx_items += 2;
        end else begin
            rx_pending.push_back(b);
            rx_items++;
        end
    endtask

    task automatic push_frame(input byte_t api, input int body_len, input byte_t dest,
                              input bit bad_sum, input int len_delta);
        byte_t body [$];
        byte_t cks;
        int    len_field;
        int    dest_pos;
        dest_pos = ((api == API_LONG) ? int'(OFFSET_LONG) : int'(OFFSET_SHORT)) - 4;
        len_field = body_len + 1 + len_delta;
        for (int k = 0; k < body_len; k++)
            body.push_back(byte_t'($urandom));
        if (dest_pos < body_len)
            body[dest_pos] = dest;
        cks = api;
        foreach (body[k])
            cks = cks + body[k];
        cks = SUM_GOOD - cks;
        if (bad_sum)
            cks = cks + byte_t'($urandom_range(255, 1));
        rx_pending.push_back(START_MARK);
        rx_items++;
        push_coded(byte_t'(len_field >> 8));
        push_coded(byte_t'(len_field));
        push_coded(api);
        foreach (body[k])
            push_coded(body[k]);
        push_coded(cks);
    endtask

    task automatic random_frame();
        int    roll;
        int    off;
        int    pay;
        int    delta;
        byte_t api;
        byte_t dest;
        roll = $urandom_range(99);
        api = ($urandom_range(9) < 7) ? API_SHORT : API_LONG;
        off = (api == API_LONG) ? int'(OFFSET_LONG) : int'(OFFSET_SHORT);
        pay = ($urandom_range(19) == 0) ? FRAME_MAX - off : $urandom_range(12, 6);
        if ($urandom_range(99) < 45)
            dest = node_addr;
        else if ($urandom_range(99) < 55)
            dest = BROADCAST;
        else
            dest = byte_t'($urandom);
        if (roll < 60) begin
            push_frame(api, pay + off - 5, dest, 1'b0, 0);
        end else if (roll < 70) begin
            push_frame(api, pay + off - 5, dest, 1'b1, 0);
        end else if (roll < 78) begin
            do api = byte_t'($urandom);
            while (api == API_LONG || api == API_SHORT);
            push_frame(api, pay + 3, dest, 1'b0, 0);
        end else if (roll < 85) begin
            push_frame(api, $urandom_range(off, 0), dest, 1'b0, 0);
        end else if (roll < 90) begin
            push_frame(api, $urandom_range(70, 60), dest, 1'b0, 0);
        end else if (roll < 95) begin
            delta = $urandom_range(6) - 3;
            push_frame(api, pay + off - 5, dest, 1'b0, (delta == 0) ? 1 : delta);
        end else begin
            // line noise between frames
            repeat ($urandom_range(6, 1)) begin
                if ($urandom_range(3) == 0)
                    rx_pending.push_back(ESC_MARK);
                else
                    rx_pending.push_back(byte_t'($urandom));
            end
        end
    endtask

    task automatic drain_all();
        while (rx_pending.size() > 0 || s_valid)
            @(posedge aclk);
        while (payload_due.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    initial begin
        bit    paused;
        byte_t phase_node;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // no idling, long receiver hold while the sender keeps offering
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b1;
        // discarded bytes, then an escape outside a frame and one more byte
        rx_pending.push_back(8'h00);
        rx_pending.push_back(8'hFF);
        rx_pending.push_back(ESC_MARK);
        rx_pending.push_back(8'h41);
        push_frame(API_SHORT, 9, BROADCAST, 1'b0, 0);
        push_frame(API_LONG, 17, NODE_RESET, 1'b0, 0);
        // restart inside an open frame
        rx_pending.push_back(START_MARK);
        rx_pending.push_back(8'h00);
        rx_pending.push_back(8'h20);
        rx_pending.push_back(API_SHORT);
        push_frame(API_SHORT, 10, NODE_RESET, 1'b0, 0);
        push_frame(API_SHORT, 9, BROADCAST, 1'b1, 0);
        push_frame(8'h90, 9, BROADCAST, 1'b0, 0);
        push_frame(API_SHORT, 9, 8'h55, 1'b0, 0);
        push_frame(API_SHORT, 7, BROADCAST, 1'b0, 0);
        push_frame(API_LONG, 5, BROADCAST, 1'b0, 0);
        push_frame(API_SHORT, 62, BROADCAST, 1'b0, 0);
        push_frame(API_LONG, 59, NODE_RESET, 1'b0, 0);
        drain_all();

        for (int ph = 1; ph < 4; ph++) begin
            case (ph)
                1: begin
                    send_idle_pct = 74;
                    recv_stall_pct = 0;
                    phase_node = 8'hFF;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 74;
                    phase_node = byte_t'($urandom);
                    apb_write(ADDR_UNUSED, $urandom);
                end
                default: begin
                    send_idle_pct = 30;
                    recv_stall_pct = 30;
                    phase_node = NODE_RESET;
                end
            endcase
            apb_write(ADDR_NODE, {24'd0, phase_node});
            rx_items = 0;
            paused = 1'b0;
            while (rx_items < 12) begin
                random_frame();
                if (!paused && rx_items >= 6) begin
                    drain_all();
                    paused = 1'b1;
                end
            end
            // close any open frame before the next register write
            push_frame(API_SHORT, 9, BROADCAST, 1'b0, 0);
            drain_all();
        end

        repeat (100) @(posedge aclk);
        if (fail_count == 0)
            $display("[escaped_radio_frame_receive_filter_core] OK");
        else
            $display("[escaped_radio_frame_receive_filter_core] ERROR");
        $finish;
    end

    initial begin
        #5000000;
        $display("[escaped_radio_frame_receive_filter_core] ERROR");
        $finish;
    end

endmodule
